@@ hdl/eia_pkg.sv @@
// shared constants, codes and types of the entity id allocator
package eia_pkg;

    localparam int POOL_SIZE   = 4096;
    localparam int FLAG_BITS   = 16;
    localparam int ID_W        = $clog2(POOL_SIZE);
    localparam int PTR_W       = $clog2(POOL_SIZE + 1);
    localparam int ENT_W       = FLAG_BITS + 1;
    localparam int CMD_W       = 3;
    localparam int STAT_W      = 2;
    localparam int IN_DATA_W   = ((ID_W + FLAG_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((ID_W + FLAG_BITS + 1 + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 3'd0,
        CMD_RELEASE = 3'd1,
        CMD_SET     = 3'd2,
        CMD_CLEAR   = 3'd3,
        CMD_QUERY   = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_NOT_LIVE  = 2'd2
    } t_status;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the incoming item
        logic commit;   // execute the held item and load the output register
        logic use_reg;  // entity table read port follows the held item
    } t_ctl;

endpackage

@@ hdl/entity_id_allocator_with_flags_core.sv @@
// top level of the entity id allocator with per-id flag words
// the accepting edge holds the item; the execute state loads the result register once the output register frees
// one item at a time: a new item is taken only after the held one commits, which writes
//   back after the registered read of the entity table and free stack
// reset: synchronous active low, clears the pointers and handshake state;
//   no clearing pass, ids at or above the high-water mark read as dead with zero flags
module entity_id_allocator_with_flags_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // entity_id [11:0], flag_mask [27:12], zero fill above
    input  logic [eia_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // command
    input  logic [eia_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // result_id [11:0], result_flags [27:12], is_live [28], zero fill above
    output logic [eia_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status
    output logic [eia_pkg::STAT_W-1:0]        m_axis_tuser
);

    localparam int IW = eia_pkg::ID_W;
    localparam int FW = eia_pkg::FLAG_BITS;

    eia_pkg::t_ctl ctl;

    logic [IW-1:0] res_id;
    logic [FW-1:0] res_flags;
    logic          res_live;

    // controller: accepts one item, then waits for the output register to free
    eia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_ctl       (ctl)
    );

    // datapath: entity table, free stack, pointers and the result register
    eia_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_cmd    (s_axis_tuser),
        .i_id     (s_axis_tdata[IW-1:0]),
        .i_mask   (s_axis_tdata[IW+FW-1:IW]),
        .o_status (m_axis_tuser),
        .o_id     (res_id),
        .o_flags  (res_flags),
        .o_live   (res_live)
    );

    // pack the result item, zero fill up to whole bytes
    assign m_axis_tdata = {{(eia_pkg::OUT_DATA_W - IW - FW - 1){1'b0}},
                           res_live, res_flags, res_id};

endmodule

@@ hdl/eia_ram.sv @@
// generic single-write, single-read ram with registered read data
module eia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/eia_ctrl.sv @@
// controller: item sequencing and output valid
module eia_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output eia_pkg::t_ctl o_ctl
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   capture, commit;

    assign capture = i_in_valid && (r_state == S_IDLE);
    assign commit  = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (capture) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_ctl.capture = capture;
    assign o_ctl.commit  = commit;
    assign o_ctl.use_reg = (r_state != S_IDLE);

endmodule

@@ hdl/eia_dp.sv @@
// datapath: free stack, entity table, pointers and result register
module eia_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  eia_pkg::t_ctl                   i_ctl,
    input  logic [eia_pkg::CMD_W-1:0]       i_cmd,
    input  logic [eia_pkg::ID_W-1:0]        i_id,
    input  logic [eia_pkg::FLAG_BITS-1:0]   i_mask,
    output logic [eia_pkg::STAT_W-1:0]      o_status,
    output logic [eia_pkg::ID_W-1:0]        o_id,
    output logic [eia_pkg::FLAG_BITS-1:0]   o_flags,
    output logic                            o_live
);

    localparam int IW = eia_pkg::ID_W;
    localparam int PW = eia_pkg::PTR_W;
    localparam int FW = eia_pkg::FLAG_BITS;
    localparam int EW = eia_pkg::ENT_W;

    // held item
    logic [eia_pkg::CMD_W-1:0] r_cmd;
    logic [IW-1:0]             r_id;
    logic [FW-1:0]             r_mask;

    // pointers
    logic [PW-1:0] r_free_top, n_free_top;
    logic [PW-1:0] r_high_water, n_high_water;

    // result register
    logic [eia_pkg::STAT_W-1:0] r_status, n_status;
    logic [IW-1:0]              r_res_id, n_res_id;
    logic [FW-1:0]              r_res_flags, n_res_flags;
    logic                       r_res_live, n_res_live;

    // memory ports
    logic          ent_we, stk_we;
    logic [IW-1:0] ent_waddr, ent_raddr, stk_raddr;
    logic [EW-1:0] ent_wdata, ent_rdata;
    logic [IW-1:0] stk_rdata;

    logic          ent_seen;
    logic          cur_live;
    logic [FW-1:0] cur_flags;
    logic [FW-1:0] new_flags;

    eia_ram #(.WIDTH(EW), .DEPTH(eia_pkg::POOL_SIZE)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    eia_ram #(.WIDTH(IW), .DEPTH(eia_pkg::POOL_SIZE)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_free_top[IW-1:0]),
        .i_wdata (r_id),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign ent_raddr = i_ctl.use_reg ? r_id : i_id;
    assign stk_raddr = r_free_top[IW-1:0] - IW'(1);

    // ids at or above the high-water mark were never written: dead, flags zero
    assign ent_seen  = ({1'b0, r_id} < r_high_water);
    assign cur_live  = ent_seen && ent_rdata[FW];
    assign cur_flags = ent_seen ? ent_rdata[FW-1:0] : '0;

    always_comb begin
        n_free_top   = r_free_top;
        n_high_water = r_high_water;
        n_status     = r_status;
        n_res_id     = r_res_id;
        n_res_flags  = r_res_flags;
        n_res_live   = r_res_live;
        ent_we       = 1'b0;
        ent_waddr    = r_id;
        ent_wdata    = '0;
        stk_we       = 1'b0;
        new_flags    = cur_flags;

        unique case (eia_pkg::t_cmd'(r_cmd))
            eia_pkg::CMD_ALLOC: begin
                n_res_flags = '0;
                if (r_free_top != '0) begin
                    n_free_top = r_free_top - PW'(1);
                    ent_waddr  = stk_rdata;
                    ent_we     = 1'b1;
                    ent_wdata  = {1'b1, {FW{1'b0}}};
                    n_status   = eia_pkg::ST_OK;
                    n_res_id   = stk_rdata;
                    n_res_live = 1'b1;
                end else if (r_high_water < PW'(eia_pkg::POOL_SIZE)) begin
                    n_high_water = r_high_water + PW'(1);
                    ent_waddr    = r_high_water[IW-1:0];
                    ent_we       = 1'b1;
                    ent_wdata    = {1'b1, {FW{1'b0}}};
                    n_status     = eia_pkg::ST_OK;
                    n_res_id     = r_high_water[IW-1:0];
                    n_res_live   = 1'b1;
                end else begin
                    n_status   = eia_pkg::ST_EXHAUSTED;
                    n_res_id   = '0;
                    n_res_live = 1'b0;
                end
            end
            eia_pkg::CMD_RELEASE: begin
                n_res_id = r_id;
                if (cur_live) begin
                    ent_we      = 1'b1;
                    ent_wdata   = '0;
                    if (r_free_top < PW'(eia_pkg::POOL_SIZE)) begin
                        stk_we     = 1'b1;
                        n_free_top = r_free_top + PW'(1);
                    end
                    n_status    = eia_pkg::ST_OK;
                    n_res_flags = '0;
                    n_res_live  = 1'b0;
                end else begin
                    n_status    = eia_pkg::ST_NOT_LIVE;
                    n_res_flags = cur_flags;
                    n_res_live  = 1'b0;
                end
            end
            eia_pkg::CMD_SET, eia_pkg::CMD_CLEAR: begin
                n_res_id = r_id;
                if (r_cmd == eia_pkg::CMD_SET) begin
                    new_flags = cur_flags | r_mask;
                end else begin
                    new_flags = cur_flags & ~r_mask;
                end
                if (cur_live) begin
                    ent_we      = 1'b1;
                    ent_wdata   = {1'b1, new_flags};
                    n_status    = eia_pkg::ST_OK;
                    n_res_flags = new_flags;
                    n_res_live  = 1'b1;
                end else begin
                    n_status    = eia_pkg::ST_NOT_LIVE;
                    n_res_flags = cur_flags;
                    n_res_live  = 1'b0;
                end
            end
            default: begin
                // query, and unused codes behave the same
                n_status    = eia_pkg::ST_OK;
                n_res_id    = r_id;
                n_res_flags = cur_flags;
                n_res_live  = cur_live;
            end
        endcase

        if (!i_ctl.commit) begin
            n_free_top   = r_free_top;
            n_high_water = r_high_water;
            n_status     = r_status;
            n_res_id     = r_res_id;
            n_res_flags  = r_res_flags;
            n_res_live   = r_res_live;
            ent_we       = 1'b0;
            stk_we       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_top   <= '0;
            r_high_water <= '0;
        end else begin
            r_free_top   <= n_free_top;
            r_high_water <= n_high_water;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd  <= i_cmd;
            r_id   <= i_id;
            r_mask <= i_mask;
        end
        r_status    <= n_status;
        r_res_id    <= n_res_id;
        r_res_flags <= n_res_flags;
        r_res_live  <= n_res_live;
    end

    assign o_status = r_status;
    assign o_id     = r_res_id;
    assign o_flags  = r_res_flags;
    assign o_live   = r_res_live;

endmodule

@@ hdl/eia_checker.sv @@
// port-level checker for the entity id allocator, bound to the top level
module eia_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [eia_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [eia_pkg::STAT_W-1:0]     m_axis_tuser
);

    localparam int LIVE_BIT = eia_pkg::ID_W + eia_pkg::FLAG_BITS;

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped before it was taken");

    // one item in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while previous item still executing");

    // exhausted pool answers with all-zero payload
    a_exhausted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == eia_pkg::ST_EXHAUSTED) |-> (m_axis_tdata == '0))
        else $error("exhausted result carries nonzero payload");

    // refused commands never report a live id
    a_refused_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == eia_pkg::ST_NOT_LIVE) |-> !m_axis_tdata[LIVE_BIT])
        else $error("refused command reports a live id");

endmodule

bind entity_id_allocator_with_flags_core eia_checker u_eia_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
